// ===== hw/rtl/sha1_stream_hasher_defines.svh =====
// ----------------------------------------------------------------------------
// sha1_stream_hasher_defines
// Assertion macros shared by the SHA-1 stream hasher RTL.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASHER_DEFINES_SVH
`define SHA1_STREAM_HASHER_DEFINES_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1_pkg
// Types and constants of the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Controller states
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LOAD  = 7'b0000010,
    ST_ROUND = 7'b0000100,
    ST_FOLD  = 7'b0001000,
    ST_PAD   = 7'b0010000,
    ST_EMIT  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  // Round function and constant for one round
  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (rnd < 7'd20) return (b & c) | (~b & d);
    else if (rnd < 7'd40) return b ^ c ^ d;
    else if (rnd < 7'd60) return (b & c) | (b & d) | (c & d);
    else return b ^ c ^ d;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    if (rnd < 7'd20) return K0;
    else if (rnd < 7'd40) return K1;
    else if (rnd < 7'd60) return K2;
    else return K3;
  endfunction

endpackage

// ===== hw/rtl/sha1_if.sv =====
// ----------------------------------------------------------------------------
// sha1_in_if / sha1_out_if
// Valid/ready channels of the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;
  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== hw/rtl/sha1_ram.sv =====
// ----------------------------------------------------------------------------
// sha1_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sha1_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/sha1_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// Streaming SHA-1 hasher, one message byte per input transfer.
// ----------------------------------------------------------------------------
// An absorb transfer is taken while the block is idle; the 64th byte of a
// block starts a compression that keeps the block busy: it reloads the
// schedule RAM as words (64 byte reads through the registered buffer read),
// runs 80 rounds, each a schedule read and then a compute and write back (the
// single round unit and the registered schedule RAM set this), and folds.
// A finish transfer pads one byte per cycle through the same path, pausing
// for each compression (9 to 72 bytes plus one or two compressions), then
// presents the five digest words in order, one per cycle while the sink is
// ready, and then restarts the chaining words in a done state. The block is
// ready again after the done state.
`include "sha1_stream_hasher_defines.svh"

module sha1_stream_hasher (
  input logic       clk,
  input logic       rst_n,
  sha1_in_if.sink   in_ch,
  sha1_out_if.source out_ch
);
  sha1_pkg::state_t state_r, state_nxt;

  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [63:0] count_r;
  logic [63:0] bits_r;
  logic        fin_r;
  logic [6:0]  rnd_r;
  logic [3:0]  pad_r;
  logic [2:0]  emit_r;
  logic        lenphase_r;

  // Byte buffer RAM (64 x 8)
  logic       buf_we;
  logic [5:0] buf_waddr, buf_raddr;
  logic [7:0] buf_wdata, buf_rdata;
  sha1_ram #(.WIDTH(8), .DEPTH(64)) u_buf (
    .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
    .raddr(buf_raddr), .rdata(buf_rdata)
  );

  // Schedule RAMs: four copies so each round reads its four taps
  logic        w_we;
  logic [3:0]  w_waddr;
  logic [31:0] w_wdata;
  logic [31:0] w_rd [4];
  logic [3:0]  w_ra [4];
  for (genvar g = 0; g < 4; g++) begin : g_wram
    sha1_ram #(.WIDTH(32), .DEPTH(16)) u_w (
      .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
      .raddr(w_ra[g]), .rdata(w_rd[g])
    );
  end

  // Current byte position and the byte to write (input or padding byte)
  logic [5:0] pos;
  logic       byte_go;
  logic [7:0] byte_val;
  assign pos = count_r[5:0];

  always_comb begin
    byte_go  = 1'b0;
    byte_val = in_ch.data_byte;
    if (state_r == sha1_pkg::ST_IDLE) begin
      byte_go = in_ch.valid && in_ch.command == sha1_pkg::CMD_ABSORB;
    end else if (state_r == sha1_pkg::ST_PAD) begin
      byte_go = 1'b1;
      if (!lenphase_r) begin
        byte_val = fin_r ? 8'h00 : sha1_pkg::PAD_BYTE;
      end else begin
        byte_val = bits_r[63 - 8*pad_r[2:0] -: 8];
      end
    end
  end

  assign in_ch.ready = (state_r == sha1_pkg::ST_IDLE);
  assign buf_we    = byte_go;
  assign buf_waddr = pos;
  assign buf_wdata = byte_val;

  // Load reads byte ld_cnt_r; word assembled from four bytes
  logic [23:0] asm_r;
  logic [6:0]  ld_cnt_r;
  logic [5:0]  ld_addr;
  assign ld_addr   = ld_cnt_r[5:0];
  assign buf_raddr = ld_addr;

  // Schedule tap addresses for round rnd_r
  logic [3:0] r4;
  assign r4 = rnd_r[3:0];
  always_comb begin
    w_ra[0] = r4 + 4'd13;
    w_ra[1] = r4 + 4'd8;
    w_ra[2] = r4 + 4'd2;
    w_ra[3] = r4;
  end

  logic [31:0] w_cur;
  logic [31:0] wx;
  assign wx    = w_rd[0] ^ w_rd[1] ^ w_rd[2] ^ w_rd[3];
  assign w_cur = (rnd_r < 7'd16) ? w_rd[3] : {wx[30:0], wx[31]};

  logic [31:0] t_val;
  assign t_val = {a_r[26:0], a_r[31:27]} + sha1_pkg::round_f(rnd_r, b_r, c_r, d_r)
               + e_r + sha1_pkg::round_k(rnd_r) + w_cur;

  // Round phase alternates: issue read, then compute
  logic rph_r;

  always_comb begin
    w_we    = 1'b0;
    w_waddr = r4;
    w_wdata = w_cur;
    if (state_r == sha1_pkg::ST_LOAD && ld_cnt_r[1:0] == 2'd0 && ld_cnt_r != 7'd0) begin
      w_we    = 1'b1;
      w_waddr = 4'(ld_cnt_r[5:2] - 4'd1);
      w_wdata = {asm_r, buf_rdata};
    end else if (state_r == sha1_pkg::ST_ROUND && rph_r && rnd_r >= 7'd16) begin
      w_we = 1'b1;
    end
  end

  // Controller
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha1_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.command == sha1_pkg::CMD_FINISH) state_nxt = sha1_pkg::ST_PAD;
          else if (pos == 6'd63) state_nxt = sha1_pkg::ST_LOAD;
        end
      end
      sha1_pkg::ST_LOAD:  if (ld_cnt_r == 7'd64) state_nxt = sha1_pkg::ST_ROUND;
      sha1_pkg::ST_ROUND: if (rph_r && rnd_r == 7'd79) state_nxt = sha1_pkg::ST_FOLD;
      sha1_pkg::ST_FOLD:  state_nxt = fin_r && lenphase_r && pad_r == 4'd8 ?
                                      sha1_pkg::ST_EMIT :
                                      (fin_r ? sha1_pkg::ST_PAD : sha1_pkg::ST_IDLE);
      sha1_pkg::ST_PAD: begin
        if (lenphase_r && pad_r == 4'd7) state_nxt = sha1_pkg::ST_LOAD;
        else if (pos == 6'd63) state_nxt = sha1_pkg::ST_LOAD;
      end
      sha1_pkg::ST_EMIT:  if (out_ch.ready && emit_r == 3'd4) state_nxt = sha1_pkg::ST_DONE;
      sha1_pkg::ST_DONE:  state_nxt = sha1_pkg::ST_IDLE;
      default:            state_nxt = sha1_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sha1_pkg::ST_IDLE;
      count_r    <= 64'd0;
      fin_r      <= 1'b0;
      lenphase_r <= 1'b0;
      pad_r      <= 4'd0;
      rnd_r      <= 7'd0;
      rph_r      <= 1'b0;
      ld_cnt_r   <= 7'd0;
      emit_r     <= 3'd0;
      h_r[0] <= sha1_pkg::H0_INIT; h_r[1] <= sha1_pkg::H1_INIT;
      h_r[2] <= sha1_pkg::H2_INIT; h_r[3] <= sha1_pkg::H3_INIT;
      h_r[4] <= sha1_pkg::H4_INIT;
    end else begin
      state_r <= state_nxt;
      if (byte_go) count_r <= count_r + 64'd1;
      // pad bookkeeping
      if (state_r == sha1_pkg::ST_IDLE && in_ch.valid &&
          in_ch.command == sha1_pkg::CMD_FINISH) begin
        bits_r <= {count_r[60:0], 3'b000};
        fin_r  <= 1'b0;
        pad_r  <= 4'd0;
        lenphase_r <= 1'b0;
      end
      if (state_r == sha1_pkg::ST_PAD) begin
        if (!lenphase_r) begin
          fin_r <= 1'b1;
          if (pos == 6'd55) lenphase_r <= 1'b1;
        end else begin
          pad_r <= pad_r + 4'd1;
        end
      end
      if (state_r == sha1_pkg::ST_FOLD && lenphase_r && pad_r == 4'd7) pad_r <= 4'd8;
      // load
      if (state_r == sha1_pkg::ST_LOAD) begin
        if (ld_cnt_r != 7'd0) asm_r <= {asm_r[15:0], buf_rdata};
        if (ld_cnt_r == 7'd64) begin
          ld_cnt_r <= 7'd0;
          rnd_r <= 7'd0; rph_r <= 1'b0;
          a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3]; e_r <= h_r[4];
        end else begin
          ld_cnt_r <= ld_cnt_r + 7'd1;
        end
      end
      // rounds
      if (state_r == sha1_pkg::ST_ROUND) begin
        rph_r <= ~rph_r;
        if (rph_r) begin
          rnd_r <= rnd_r + 7'd1;
          a_r <= t_val; b_r <= a_r; c_r <= {b_r[1:0], b_r[31:2]}; d_r <= c_r; e_r <= d_r;
        end
      end
      if (state_r == sha1_pkg::ST_FOLD) begin
        h_r[0] <= h_r[0] + a_r; h_r[1] <= h_r[1] + b_r; h_r[2] <= h_r[2] + c_r;
        h_r[3] <= h_r[3] + d_r; h_r[4] <= h_r[4] + e_r;
      end
      // emit; hold the index on the last word
      if (state_r == sha1_pkg::ST_EMIT && out_ch.ready && emit_r != 3'd4) begin
        emit_r <= emit_r + 3'd1;
      end
      if (state_r == sha1_pkg::ST_DONE) begin
        emit_r <= 3'd0; count_r <= 64'd0; fin_r <= 1'b0; lenphase_r <= 1'b0;
        pad_r <= 4'd0;
        h_r[0] <= sha1_pkg::H0_INIT; h_r[1] <= sha1_pkg::H1_INIT;
        h_r[2] <= sha1_pkg::H2_INIT; h_r[3] <= sha1_pkg::H3_INIT;
        h_r[4] <= sha1_pkg::H4_INIT;
      end
    end
  end

  assign out_ch.valid       = (state_r == sha1_pkg::ST_EMIT);
  assign out_ch.digest_word = h_r[emit_r];
  assign out_ch.word_index  = emit_r;
  assign out_ch.last_word   = (emit_r == 3'd4);

  // Last digest word leaves on this transfer
  logic emit_last;
  assign emit_last = out_ch.valid && out_ch.ready && out_ch.last_word;

  `SHA_ASSERT_IMP(a_last_idx, clk, rst_n, out_ch.last_word, emit_r == 3'd4, "last flag off")
  `SHA_ASSERT_NEXT(a_emit_done, clk, rst_n, emit_last, state_r == sha1_pkg::ST_DONE, "no done")
  `SHA_ASSERT_IMP(a_busy, clk, rst_n, state_r != sha1_pkg::ST_IDLE, !in_ch.ready, "ready busy")
endmodule
